// ----- sv/mqsa_pkg.sv -----
// ----------------------------------------------------------------------------
// mqsa_pkg : shared multi-query aggregation, common types and constants
// Operation codes, register indexes, identity values and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsa_pkg;

	localparam int MASK_W  = 32;
	localparam int VALUE_W = 32;
	localparam int SEL_W   = 5;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 64;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_QUERIES = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_OPS      = 8'd1;

	localparam logic [VALUE_W-1:0] INT_MAX    = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] INT_MIN    = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] NULL_VALUE = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_MIN   = 2'd0,
		OP_MAX   = 2'd1,
		OP_SUM   = 2'd2,
		OP_COUNT = 2'd3
	} agg_op_t;

	typedef enum logic {
		REQ_ACCUMULATE = 1'b0,
		REQ_READ       = 1'b1
	} req_type_t;

	function automatic logic [VALUE_W-1:0] op_identity(agg_op_t op);
		logic [VALUE_W-1:0] id;
		case (op)
			OP_MIN:  id = INT_MAX;
			OP_MAX:  id = INT_MIN;
			default: id = '0;
		endcase
		return id;
	endfunction

endpackage

`default_nettype wire

// ----- sv/multi_query_shared_aggregation.sv -----
// ----------------------------------------------------------------------------
// multi_query_shared_aggregation : shared aggregation over many queries
// Walks the query slots of each tuple through one update unit and answers
// read requests with a slot's current min, max, sum or count.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries a request word, s_tuser its type (accumulate or read); m_* returns
//   one word per read request: slot id and aggregate. The user must write cfg_*
//   active_queries (index 0) and query_ops (index 1) only while idle (not enforced).
// Timing:
//   An accumulate word walks every slot in turn through a single
//   read-modify-write unit on the accumulator memory: it is accepted, walks
//   QUERY_SLOTS slots (capped at 32), then makes the final write before the
//   next word is taken.
//   A read word reads the memory at the accepting edge and selects the result
//   in the next cycle; the result moves into the output register when it is
//   free, and no new request word is taken before that.
//   The output register is separate, so accumulate words are taken while a
//   result waits; a read word waits in the select stage until it frees.
// Reset:
//   Clears the registers, the touched bits and the output; no memory sweep
//   is needed, an untouched slot reads as its operation's identity.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_query_shared_aggregation
	import mqsa_pkg::*;
#(
	parameter int QUERY_SLOTS = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	// request words
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire  [S_TDATA_W-1:0]        s_tdata,   // query_mask, value, query_sel, zero pad
	input  wire                         s_tuser,   // req_type
	// result words
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [M_TDATA_W-1:0]        m_tdata,   // query_id, aggregate, zero pad
	// register writes
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  [CFG_IDX_W-1:0]        cfg_index,
	input  wire  [CFG_DATA_W-1:0]       cfg_data
);

	localparam int SLOTS = (QUERY_SLOTS < MASK_W) ? QUERY_SLOTS : MASK_W;
	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_RESP
	} state_t;

	state_t                 state_q;
	logic [CFG_DATA_W-1:0]  ops_q;
	logic [MASK_W-1:0]      active_q;
	logic [SLOTS-1:0]       touched_q;
	logic [SLOTS-1:0]       hits_q;
	logic [VALUE_W-1:0]     value_q;
	logic [IW-1:0]          idx_q;
	logic [SEL_W-1:0]       sel_q;
	logic                   upd_s1;
	logic [IW-1:0]          slot_s1;
	logic                   m_tvalid_q;
	logic [SEL_W-1:0]       m_query_id_q;
	logic [VALUE_W-1:0]     m_aggregate_q;

	logic [VALUE_W-1:0]     mem [SLOTS];
	logic [VALUE_W-1:0]     rdata_q;

	logic                   s_accept;
	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic [MASK_W-1:0]      in_mask;
	logic [VALUE_W-1:0]     in_value;
	logic [SEL_W-1:0]       in_sel;
	logic [CFG_DATA_W-1:0]  ops_upd;
	agg_op_t                op_upd;
	logic [VALUE_W-1:0]     base_upd;
	logic [VALUE_W-1:0]     acc_new;
	logic [CFG_DATA_W-1:0]  ops_rd;
	agg_op_t                op_rd;
	logic                   sel_out_of_range;
	logic [VALUE_W-1:0]     result;
	logic                   out_free;

	assign in_mask  = s_tdata[MASK_W-1:0];
	assign in_value = s_tdata[MASK_W +: VALUE_W];
	assign in_sel   = s_tdata[MASK_W+VALUE_W +: SEL_W];

	assign s_tready  = (state_q == ST_IDLE) && !upd_s1;
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	assign rd_en   = (state_q == ST_WALK) || (s_accept && (s_tuser == REQ_READ));
	assign rd_addr = (state_q == ST_WALK) ? idx_q : in_sel[IW-1:0];

	// read-modify-write unit
	always_comb begin
		ops_upd  = ops_q >> {slot_s1, 1'b0};
		op_upd   = agg_op_t'(ops_upd[1:0]);
		base_upd = touched_q[slot_s1] ? rdata_q : op_identity(op_upd);
		acc_new  = base_upd;
		if (value_q != NULL_VALUE) begin
			case (op_upd)
				OP_MIN: begin
					if ($signed(value_q) < $signed(base_upd))
						acc_new = value_q;
				end
				OP_MAX: begin
					if ($signed(value_q) > $signed(base_upd))
						acc_new = value_q;
				end
				OP_SUM:   acc_new = base_upd + value_q;
				OP_COUNT: acc_new = base_upd + 32'd1;
				default:  acc_new = base_upd;
			endcase
		end
	end

	// read result select
	always_comb begin
		ops_rd           = ops_q >> {sel_q, 1'b0};
		op_rd            = agg_op_t'(ops_rd[1:0]);
		sel_out_of_range = {{(32-SEL_W){1'b0}}, sel_q} >= 32'(QUERY_SLOTS);
		if (sel_out_of_range)
			result = '0;
		else if (touched_q[sel_q[IW-1:0]])
			result = rdata_q;
		else
			result = op_identity(op_rd);
	end

	always_ff @(posedge clk) begin
		if (upd_s1)
			mem[slot_s1] <= acc_new;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ops_q         <= '0;
			active_q      <= '0;
			touched_q     <= '0;
			hits_q        <= '0;
			value_q       <= '0;
			idx_q         <= '0;
			sel_q         <= '0;
			upd_s1        <= 1'b0;
			slot_s1       <= '0;
			m_tvalid_q    <= 1'b0;
			m_query_id_q  <= '0;
			m_aggregate_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ACTIVE_QUERIES)
					active_q <= cfg_data[MASK_W-1:0];
				else if (cfg_index == REG_QUERY_OPS)
					ops_q <= cfg_data;
			end

			if (upd_s1)
				touched_q[slot_s1] <= 1'b1;

			if (m_tvalid_q && m_tready && (state_q != ST_RESP))
				m_tvalid_q <= 1'b0;

			upd_s1 <= (state_q == ST_WALK) && hits_q[idx_q];

			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						if (s_tuser == REQ_READ) begin
							sel_q   <= in_sel;
							state_q <= ST_RESP;
						end else begin
							hits_q  <= in_mask[SLOTS-1:0] & active_q[SLOTS-1:0];
							value_q <= in_value;
							idx_q   <= '0;
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					slot_s1 <= idx_q;
					if (idx_q == LAST_IDX)
						state_q <= ST_IDLE;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_RESP: begin
					if (out_free) begin
						m_tvalid_q    <= 1'b1;
						m_query_id_q  <= sel_q;
						m_aggregate_q <= result;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-SEL_W-VALUE_W){1'b0}}, m_aggregate_q, m_query_id_q};

`ifndef SYNTHESIS
	a_touch_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		upd_s1 |=> touched_q[$past(slot_s1)])
		else $error("slot not marked touched after update");

	a_read_goes_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_tuser == REQ_READ) |=> (state_q == ST_RESP))
		else $error("read word did not reach result select");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_RESP))
		else $error("result raised outside result select");

	a_no_update_while_reading: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) |-> !upd_s1)
		else $error("accumulator write during read");
`endif

endmodule

`default_nettype wire
